/* design/assert_macros.svh */
// Concurrent assertion helpers shared by the RTL.
// Build with NO_ASSERTIONS defined to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication: cons must hold whenever ante holds.
`define CO2IV_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("co2iv implication check failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define CO2IV_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("co2iv next-cycle check failed");

`else

`define CO2IV_ASSERT_IMP(label, clk, rstn, ante, cons)
`define CO2IV_ASSERT_NXT(label, clk, rstn, ante, cons)

`endif

`endif

/* design/co2iv_pkg.sv */
`timescale 1ns / 1ps

package co2iv_pkg;

    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET      = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND        = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL    = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VENT_MARGIN = 4'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VALVE_GAIN  = 4'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FAN_GAIN    = 4'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_MIXING      = 4'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_VENT = 4'd7;

    localparam logic [10:0] TARGET_LOW  = 11'd200;
    localparam logic [10:0] TARGET_HIGH = 11'd1500;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    typedef enum logic [2:0] {
        MODE_IDLE      = 3'd0,
        MODE_INJECTING = 3'd1,
        MODE_MIXING    = 3'd2,
        MODE_EMERG     = 3'd3,
        MODE_VENT      = 3'd4
    } mode_t;

    typedef struct packed {
        logic [10:0] target_ppm;
        logic [9:0]  band_ppm;
        logic [13:0] critical_ppm;
        logic [12:0] vent_margin_ppm;
        logic [15:0] valve_gain_q8;
        logic [15:0] fan_gain_q8;
        logic [15:0] mixing_ms;
        logic        active_vent_on;
    } cfg_t;

    typedef struct packed {
        mode_t       mode;
        logic [15:0] valve_timer;
        logic [15:0] mixing_timer;
        logic [13:0] last_co2;
        logic [9:0]  fan_level;
        logic        valve_state;
        logic        warning;
    } ctl_state_t;

endpackage

/* design/co2iv_cfg_regs.sv */
`timescale 1ns / 1ps

module co2iv_cfg_regs
    import co2iv_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic target_ok;

    assign target_ok = (wr_data[10:0] >= TARGET_LOW) && (wr_data[10:0] <= TARGET_HIGH);

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (wr_index)
                CFG_TARGET: begin
                    // drop a setpoint outside the legal window
                    if (target_ok) begin
                        cfg_next.target_ppm = wr_data[10:0];
                    end
                end
                CFG_BAND:        cfg_next.band_ppm        = wr_data[9:0];
                CFG_CRITICAL:    cfg_next.critical_ppm    = wr_data[13:0];
                CFG_VENT_MARGIN: cfg_next.vent_margin_ppm = wr_data[12:0];
                CFG_VALVE_GAIN:  cfg_next.valve_gain_q8   = wr_data;
                CFG_FAN_GAIN:    cfg_next.fan_gain_q8     = wr_data;
                CFG_MIXING:      cfg_next.mixing_ms       = wr_data;
                CFG_ACTIVE_VENT: cfg_next.active_vent_on  = wr_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_ppm      <= 11'd800;
            cfg_reg.band_ppm        <= 10'd50;
            cfg_reg.critical_ppm    <= 14'd2000;
            cfg_reg.vent_margin_ppm <= 13'd200;
            cfg_reg.valve_gain_q8   <= 16'd2560;
            cfg_reg.fan_gain_q8     <= 16'd256;
            cfg_reg.mixing_ms       <= 16'd10000;
            cfg_reg.active_vent_on  <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* design/co2iv_step.sv */
`timescale 1ns / 1ps

module co2iv_step
    import co2iv_pkg::*;
#(
    parameter int unsigned VALVE_MIN_MS = 100,
    parameter int unsigned VALVE_MAX_MS = 10000,
    parameter int unsigned FAN_MIN      = 100,
    parameter int unsigned FAN_MAX      = 1000
) (
    input  cfg_t        cfg,
    input  ctl_state_t  cur,
    input  logic        req_type,
    input  logic [13:0] co2_ppm,
    output ctl_state_t  nxt
);

    logic [11:0] thr_band;      // target + band
    logic [14:0] co2_band;      // co2 + band
    logic [13:0] thr_vent;      // target + vent margin
    logic        enter_emerg;
    mode_t       mode_pre;
    logic [13:0] valve_diff;
    logic [13:0] fan_diff;
    logic [13:0] mul_a;
    logic [15:0] mul_b;
    logic [29:0] prod;
    logic [21:0] scaled;
    logic [15:0] valve_time;
    logic [9:0]  fan_drive;

    assign thr_band    = {1'b0, cfg.target_ppm} + {2'b00, cfg.band_ppm};
    assign co2_band    = {1'b0, co2_ppm} + {5'd0, cfg.band_ppm};
    assign thr_vent    = {3'd0, cfg.target_ppm} + {1'b0, cfg.vent_margin_ppm};
    assign enter_emerg = (co2_ppm > cfg.critical_ppm) && (cur.mode != MODE_EMERG);
    assign mode_pre    = enter_emerg ? MODE_EMERG : cur.mode;

    // Only one of the two products is ever used for a sample, so share the multiplier.
    assign valve_diff = {2'b00, thr_band} - co2_ppm;
    assign fan_diff   = co2_ppm - {2'b00, thr_band};
    assign mul_a      = (mode_pre == MODE_IDLE) ? valve_diff : fan_diff;
    assign mul_b      = (mode_pre == MODE_IDLE) ? cfg.valve_gain_q8 : cfg.fan_gain_q8;
    assign prod       = {16'd0, mul_a} * {14'd0, mul_b};
    assign scaled     = prod[29:8];

    // Clamp high first, then low.
    always_comb begin
        if (scaled > 22'(VALVE_MAX_MS)) begin
            valve_time = 16'(VALVE_MAX_MS);
        end else if (scaled < 22'(VALVE_MIN_MS)) begin
            valve_time = 16'(VALVE_MIN_MS);
        end else begin
            valve_time = scaled[15:0];
        end
        if (scaled > 22'(FAN_MAX)) begin
            fan_drive = 10'(FAN_MAX);
        end else if (scaled < 22'(FAN_MIN)) begin
            fan_drive = 10'(FAN_MIN);
        end else begin
            fan_drive = scaled[9:0];
        end
    end

    always_comb begin
        nxt = cur;
        if (req_type == REQ_TICK) begin
            if (cur.mixing_timer != 16'd0) begin
                nxt.mixing_timer = cur.mixing_timer - 16'd1;
                if (nxt.mixing_timer == 16'd0 && nxt.mode == MODE_MIXING) begin
                    nxt.mode = MODE_IDLE;
                end
            end
            if (cur.valve_timer != 16'd0) begin
                nxt.valve_timer = cur.valve_timer - 16'd1;
                if (nxt.valve_timer == 16'd0 && nxt.mode == MODE_INJECTING) begin
                    nxt.valve_state  = 1'b0;
                    nxt.mode         = MODE_MIXING;
                    nxt.mixing_timer = (cfg.mixing_ms != 16'd0) ? cfg.mixing_ms : 16'd1;
                end
            end
        end else begin
            nxt.last_co2 = co2_ppm;
            if (enter_emerg) begin
                nxt.valve_state  = 1'b0;
                nxt.fan_level    = 10'(FAN_MAX);
                nxt.valve_timer  = 16'd0;
                nxt.mixing_timer = 16'd0;
                nxt.mode         = MODE_EMERG;
                nxt.warning      = 1'b1;
            end
            unique case (mode_pre)
                MODE_IDLE: begin
                    if (co2_band < {4'd0, cfg.target_ppm}) begin
                        nxt.fan_level   = 10'd0;
                        nxt.valve_timer = valve_time;
                        nxt.valve_state = 1'b1;
                        nxt.mode        = MODE_INJECTING;
                    end else if (co2_ppm > thr_vent) begin
                        nxt.valve_state = 1'b0;
                        if (cfg.active_vent_on) begin
                            nxt.mode = MODE_VENT;
                        end
                    end else begin
                        nxt.valve_state  = 1'b0;
                        nxt.fan_level    = 10'd0;
                        nxt.valve_timer  = 16'd0;
                        nxt.mixing_timer = 16'd0;
                        nxt.warning      = 1'b0;
                    end
                end
                MODE_VENT: begin
                    if (!cfg.active_vent_on || co2_ppm <= {2'b00, thr_band}) begin
                        nxt.fan_level = 10'd0;
                        nxt.mode      = MODE_IDLE;
                    end else begin
                        nxt.fan_level = fan_drive;
                    end
                end
                MODE_EMERG: begin
                    if (co2_ppm <= {2'b00, thr_band}) begin
                        nxt.fan_level = 10'd0;
                        nxt.mode      = MODE_IDLE;
                        nxt.warning   = 1'b0;
                    end else begin
                        nxt.fan_level = fan_drive;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

/* design/co2_injection_ventilation_controller.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// CO2 injection and ventilation controller. Each input beat is either a sensor
// sample (s_req_type = 0, level in s_co2_ppm) or a one-millisecond tick
// (s_req_type = 1), and each one yields exactly one result beat with the valve,
// fan, warning, mode and latest level as they stand after that item. A sample
// above critical_ppm forces emergency ventilation and raises m_warning; in idle
// a low level opens the valve for a clamped proportional time, after which the
// block waits through the mixing period; a high level with active_vent_on set
// drives the fan proportionally. Throughput is one item per clock while m_ready
// stays high: an item is held in the input register, then a single pass of
// compare, one shared 14x16 multiply and clamp updates the controller state,
// which is also the result register. An accepted item passes the input register
// and then the state register; it waits in the input register while an earlier
// result is untaken, and an empty input register still accepts then, so one
// further item can be parked. Configuration writes (cfg_valid/cfg_ready, index
// as listed below) are always accepted and should only be issued while the
// block holds no pending item. Register indexes: 0 target_ppm (writes outside
// 200..1500 are dropped), 1 band_ppm, 2 critical_ppm, 3 vent_margin_ppm,
// 4 valve_gain_q8, 5 fan_gain_q8, 6 mixing_ms, 7 active_vent_on; higher
// indexes are ignored. Gains are unsigned Q8.8 with the product truncated.
module co2_injection_ventilation_controller
    import co2iv_pkg::*;
#(
    parameter int unsigned VALVE_MIN_MS = 100,
    parameter int unsigned VALVE_MAX_MS = 10000,
    parameter int unsigned FAN_MIN      = 100,
    parameter int unsigned FAN_MAX      = 1000
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_req_type,
    input  logic [13:0]           s_co2_ppm,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_valve_open,
    output logic [9:0]            m_fan_speed,
    output logic                  m_warning,
    output logic [2:0]            m_mode,
    output logic [13:0]           m_co2_level,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t        cfg;
    ctl_state_t  state_reg;
    ctl_state_t  state_next;

    logic        in_vld_reg;
    logic        in_vld_next;
    logic        in_req_reg;
    logic [13:0] in_co2_reg;
    logic        m_valid_reg;
    logic        m_valid_next;
    logic        advance;
    logic        s_fire;

    assign cfg_ready = 1'b1;

    co2iv_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Advance the held item into the state once the result slot is free.
    assign advance = in_vld_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        priority if (s_fire) begin
            in_vld_next = 1'b1;
        end else if (advance) begin
            in_vld_next = 1'b0;
        end else begin
            in_vld_next = in_vld_reg;
        end
        priority if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    co2iv_step #(
        .VALVE_MIN_MS (VALVE_MIN_MS),
        .VALVE_MAX_MS (VALVE_MAX_MS),
        .FAN_MIN      (FAN_MIN),
        .FAN_MAX      (FAN_MAX)
    ) u_step (
        .cfg      (cfg),
        .cur      (state_reg),
        .req_type (in_req_reg),
        .co2_ppm  (in_co2_reg),
        .nxt      (state_next)
    );

    // Input register payload: load on accept, hold otherwise.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_req_reg <= s_req_type;
            in_co2_reg <= s_co2_ppm;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg            <= 1'b0;
            m_valid_reg           <= 1'b0;
            state_reg.mode        <= MODE_IDLE;
            state_reg.valve_timer <= 16'd0;
            state_reg.mixing_timer <= 16'd0;
            state_reg.last_co2    <= 14'd0;
            state_reg.fan_level   <= 10'd0;
            state_reg.valve_state <= 1'b0;
            state_reg.warning     <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            m_valid_reg <= m_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    // The controller state doubles as the result register.
    assign m_valid      = m_valid_reg;
    assign m_valve_open = state_reg.valve_state;
    assign m_fan_speed  = state_reg.fan_level;
    assign m_warning    = state_reg.warning;
    assign m_mode       = state_reg.mode;
    assign m_co2_level  = state_reg.last_co2;

    // Warning is raised only on the way into emergency and cleared on the way out.
    `CO2IV_ASSERT_IMP(a_warn_in_emerg, aclk, aresetn, m_warning, m_mode == MODE_EMERG)
    // The valve is open only while injecting.
    `CO2IV_ASSERT_IMP(a_valve_in_inject, aclk, aresetn, m_valve_open, m_mode == MODE_INJECTING)
    // A running mixing timer belongs to the mixing phase.
    `CO2IV_ASSERT_IMP(a_mix_timer_mode, aclk, aresetn, state_reg.mixing_timer != 16'd0, state_reg.mode == MODE_MIXING)
    // The fan runs only in emergency or ventilating.
    `CO2IV_ASSERT_IMP(a_fan_mode, aclk, aresetn, m_fan_speed != 10'd0, (m_mode == MODE_EMERG) || (m_mode == MODE_VENT))
    // With nothing held in the input register, a taken result leaves the slot empty.
    `CO2IV_ASSERT_NXT(a_out_drains, aclk, aresetn, m_valid && m_ready && !in_vld_reg, !m_valid)

endmodule
